// ===== hw/rtl/kfp_pkg.sv =====
// Shared constants, codes and types for the keyframe frame planner.
package kfp_pkg;

  localparam int MAX_POSES     = 256;
  localparam int POSE_ID_RANGE = 1024;

  localparam int SLOT_W   = 8;
  localparam int ID_W     = 10;
  localparam int TIME_W   = 32;
  localparam int FPS_W    = 8;
  localparam int CNT_W    = 9;
  localparam int FRAME_W  = 31;
  localparam int WIDE_W   = 42;
  localparam int SCALED_W = 40;
  localparam int DUR_W    = 10;
  localparam int CUT_AW   = 10;
  localparam int CFG_AW   = 2;
  localparam int CFG_DW   = 32;

  localparam int MS_PER_S = 1000;

  localparam logic [FPS_W-1:0] FPS_RESET = 8'd30;

  localparam logic [1:0] OP_POSE    = 2'd0;
  localparam logic [1:0] OP_CUT     = 2'd1;
  localparam logic [1:0] OP_TICK    = 2'd2;
  localparam logic [1:0] OP_RESTART = 2'd3;

  localparam logic [1:0] KIND_BLANK  = 2'd0;
  localparam logic [1:0] KIND_COPY   = 2'd1;
  localparam logic [1:0] KIND_HOLD   = 2'd2;
  localparam logic [1:0] KIND_INTERP = 2'd3;

  localparam logic [CFG_AW-1:0] CFG_FPS   = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_END   = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_COUNT = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_P0,
    ST_CHK,
    ST_RDN,
    ST_DEC,
    ST_FIN
  } state_t;

endpackage

// ===== hw/rtl/keyframe_frame_planner_unit.sv =====
// Keyframe frame planner: pose table, cut map and per-tick frame planning.
//
// Input channel (item_valid/item_stall) carries one op per transfer: pose slot
// write, cut mark write, frame tick or restart. Writes and restart take effect
// as they are accepted. A tick runs ST_P0 and ST_CHK, then returns to idle
// when the frame lies past the end of the timeline (no result), goes to ST_FIN
// for a blank frame, and otherwise runs ST_RDN and ST_DEC once plus once per
// table entry the pose pointer skips, each entry read from the pose table port.
// Result channel (result_valid/result_stall) holds one frame in an output
// register; the next op is taken while it waits. A tick that finishes while
// the output register is still stalled waits in its last cycle.
// Configuration port (cfg_valid/cfg_ready) is always ready; write it only
// while the block is idle.
// After reset all 1024 cut map entries are swept to zero, during which
// item_stall stays high. Pose table contents are undefined until written.
module keyframe_frame_planner_unit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [kfp_pkg::CFG_AW-1:0]    cfg_index,
  input  logic [kfp_pkg::CFG_DW-1:0]    cfg_data,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  logic [1:0]                    op,
  input  logic [kfp_pkg::SLOT_W-1:0]    slot,
  input  logic [kfp_pkg::TIME_W-1:0]    pose_time,
  input  logic [kfp_pkg::ID_W-1:0]      pose_id,
  input  logic                          cut_on,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic [1:0]                    kind,
  output logic [kfp_pkg::ID_W-1:0]      first_pose,
  output logic [kfp_pkg::ID_W-1:0]      second_pose,
  output logic [kfp_pkg::SLOT_W-1:0]    table_position,
  output logic [kfp_pkg::WIDE_W-1:0]    step_num,
  output logic [kfp_pkg::WIDE_W-1:0]    step_den,
  output logic [kfp_pkg::WIDE_W-1:0]    time_num,
  output logic [kfp_pkg::DUR_W-1:0]     duration_num,
  output logic                          last_frame
);
  import kfp_pkg::*;

  logic [FPS_W-1:0]  frames_per_second;
  logic [TIME_W-1:0] end_time_ms;
  logic [CNT_W-1:0]  pose_count;
  logic [CNT_W-1:0]  count_eff;
  logic [CNT_W-1:0]  count_m1;

  state_t state, state_next;

  logic              clr_busy;
  logic [CUT_AW-1:0] clr_addr;

  logic [SLOT_W-1:0]  current_pose;
  logic [SLOT_W-1:0]  k;
  logic [SLOT_W-1:0]  k_start;
  logic [FRAME_W-1:0] frame_number;

  logic [WIDE_W-1:0]   t_sc;
  logic [SCALED_W-1:0] end_sc;
  logic [SCALED_W-1:0] tk_sc;
  logic [SCALED_W-1:0] tn_sc;
  logic [ID_W-1:0]     id_k;
  logic [ID_W-1:0]     id_n;
  logic [1:0]          kind_w;

  logic [TIME_W+ID_W-1:0] pose_mem [MAX_POSES];
  logic [TIME_W+ID_W-1:0] pose_rdata;
  logic [SLOT_W-1:0]      pose_raddr;
  logic                   pose_we;

  logic              cut_mem [POSE_ID_RANGE];
  logic              cut_rdata;
  logic [CUT_AW-1:0] cut_raddr;
  logic [CUT_AW-1:0] cut_waddr;
  logic              cut_we;
  logic              cut_wdata;

  logic [TIME_W-1:0]   rd_time;
  logic [ID_W-1:0]     rd_id;
  logic [SCALED_W-1:0] rd_scaled;
  logic [SCALED_W-1:0] end_mul;
  logic [WIDE_W-1:0]   t_mul;

  logic              item_fire;
  logic              out_free;
  logic [CNT_W-1:0]  k_plus1;
  logic              has_next;
  logic              advance;
  logic              past_end;
  logic              before_first;
  logic              is_interp;
  logic              is_blank;
  logic [WIDE_W:0]   t_after;
  logic              last_w;
  logic [WIDE_W-1:0] remain;

  assign cfg_ready = 1'b1;

  assign count_eff = (pose_count > CNT_W'(MAX_POSES)) ? CNT_W'(MAX_POSES) : pose_count;
  assign count_m1  = count_eff - CNT_W'(1);
  assign k_start   = (count_eff != '0 && {1'b0, current_pose} >= count_eff) ?
                     count_m1[SLOT_W-1:0] : current_pose;

  assign rd_time   = pose_rdata[TIME_W+ID_W-1:ID_W];
  assign rd_id     = pose_rdata[ID_W-1:0];
  assign rd_scaled = rd_time * frames_per_second;
  assign end_mul   = end_time_ms * frames_per_second;
  assign t_mul     = frame_number * WIDE_W'(MS_PER_S);

  assign item_stall   = (state != ST_IDLE) || clr_busy;
  assign item_fire    = item_valid && !item_stall;
  assign out_free     = !result_valid || !result_stall;
  assign k_plus1      = {1'b0, k} + CNT_W'(1);
  assign has_next     = k_plus1 < count_eff;
  assign advance      = has_next && ({2'b0, tn_sc} <= t_sc);
  assign past_end     = t_sc >= {2'b0, end_sc};
  assign before_first = (count_eff == '0) || (t_sc < {2'b0, tn_sc});

  assign is_interp = kind_w == KIND_INTERP;
  assign is_blank  = kind_w == KIND_BLANK;
  assign t_after   = {1'b0, t_sc} + (WIDE_W+1)'(MS_PER_S);
  assign last_w    = t_after >= {3'b0, end_sc};
  assign remain    = {2'b0, end_sc} - t_sc;

  assign pose_we   = item_fire && op == OP_POSE;
  assign cut_we    = clr_busy || (item_fire && op == OP_CUT);
  assign cut_waddr = clr_busy ? clr_addr : pose_id;
  assign cut_wdata = clr_busy ? 1'b0 : cut_on;
  assign cut_raddr = rd_id;

  always_ff @(posedge clk) begin
    if (pose_we) begin
      pose_mem[slot] <= {pose_time, pose_id};
    end
    pose_rdata <= pose_mem[pose_raddr];
  end

  always_ff @(posedge clk) begin
    if (cut_we) begin
      cut_mem[cut_waddr] <= cut_wdata;
    end
    cut_rdata <= cut_mem[cut_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pose_raddr = k;
    unique case (state)
      ST_IDLE: begin
        pose_raddr = '0;
        if (item_fire && op == OP_TICK) begin
          state_next = ST_P0;
        end
      end
      ST_P0: begin
        pose_raddr = k;
        state_next = ST_CHK;
      end
      ST_CHK: begin
        pose_raddr = k_plus1[SLOT_W-1:0];
        priority if (past_end) begin
          state_next = ST_IDLE;
        end else if (before_first) begin
          state_next = ST_FIN;
        end else begin
          state_next = ST_RDN;
        end
      end
      ST_RDN: begin
        state_next = ST_DEC;
      end
      ST_DEC: begin
        pose_raddr = k + SLOT_W'(2);
        state_next = advance ? ST_RDN : ST_FIN;
      end
      ST_FIN: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      frames_per_second <= FPS_RESET;
      end_time_ms       <= '0;
      pose_count        <= '0;
      current_pose      <= '0;
      frame_number      <= '0;
      clr_busy          <= 1'b1;
      clr_addr          <= '0;
      result_valid      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_FPS:   frames_per_second <= cfg_data[FPS_W-1:0];
          CFG_END:   end_time_ms       <= cfg_data[TIME_W-1:0];
          CFG_COUNT: pose_count        <= cfg_data[CNT_W-1:0];
          default: begin
          end
        endcase
      end
      if (clr_busy) begin
        clr_addr <= clr_addr + CUT_AW'(1);
        if (&clr_addr) begin
          clr_busy <= 1'b0;
        end
      end
      if (state == ST_FIN && out_free) begin
        result_valid <= 1'b1;
      end else if (result_valid && !result_stall) begin
        result_valid <= 1'b0;
      end
      if (item_fire && op == OP_RESTART) begin
        frame_number <= '0;
        current_pose <= '0;
      end
      if (state == ST_FIN && out_free) begin
        frame_number <= frame_number + FRAME_W'(1);
        if (!is_blank) begin
          current_pose <= k;
        end
      end
    end
  end

  // working and result payload
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (item_fire && op == OP_TICK) begin
          t_sc   <= t_mul;
          end_sc <= end_mul;
          k      <= k_start;
        end
      end
      ST_P0: begin
        tn_sc <= rd_scaled;
      end
      ST_CHK: begin
        tk_sc <= rd_scaled;
        id_k  <= rd_id;
        if (before_first) begin
          kind_w <= KIND_BLANK;
        end
      end
      ST_RDN: begin
        tn_sc <= rd_scaled;
        id_n  <= rd_id;
      end
      ST_DEC: begin
        if (advance) begin
          k     <= k_plus1[SLOT_W-1:0];
          tk_sc <= tn_sc;
          id_k  <= id_n;
        end else begin
          priority if (t_sc == {2'b0, tk_sc}) begin
            kind_w <= KIND_COPY;
          end else if (!has_next || cut_rdata) begin
            kind_w <= KIND_HOLD;
          end else begin
            kind_w <= KIND_INTERP;
          end
        end
      end
      ST_FIN: begin
        if (out_free) begin
          kind           <= kind_w;
          first_pose     <= is_blank ? '0 : id_k;
          second_pose    <= is_interp ? id_n : '0;
          table_position <= is_interp ? k : '0;
          step_num       <= is_interp ? (t_sc - {2'b0, tk_sc}) : '0;
          step_den       <= is_interp ? ({2'b0, tn_sc} - {2'b0, tk_sc}) : '0;
          time_num       <= t_sc;
          duration_num   <= last_w ? remain[DUR_W-1:0] : DUR_W'(MS_PER_S);
          last_frame     <= last_w;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== hw/rtl/kfp_checker.sv =====
// Port-level checks for the keyframe frame planner, bound to the top level.
module kfp_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          item_stall,
  input logic                          result_valid,
  input logic                          result_stall,
  input logic [1:0]                    kind,
  input logic [kfp_pkg::ID_W-1:0]      first_pose,
  input logic [kfp_pkg::ID_W-1:0]      second_pose,
  input logic [kfp_pkg::SLOT_W-1:0]    table_position,
  input logic [kfp_pkg::WIDE_W-1:0]    step_num,
  input logic [kfp_pkg::WIDE_W-1:0]    step_den,
  input logic [kfp_pkg::WIDE_W-1:0]    time_num,
  input logic [kfp_pkg::DUR_W-1:0]     duration_num,
  input logic                          last_frame
);
  import kfp_pkg::*;

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=>
      result_valid && $stable(kind) && $stable(time_num) && $stable(first_pose))
    else $error("stalled result changed");

  a_clear_after_reset: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> item_stall)
    else $error("input taken during cut map clear");

  a_duration: assert property (@(posedge clk) disable iff (rst)
    result_valid |->
      (last_frame ? (duration_num != '0) : (duration_num == DUR_W'(MS_PER_S))))
    else $error("frame duration out of range");

  a_blank_fields: assert property (@(posedge clk) disable iff (rst)
    result_valid && kind == KIND_BLANK |-> first_pose == '0 && step_num == '0)
    else $error("blank frame carries pose data");

  a_interp_only: assert property (@(posedge clk) disable iff (rst)
    result_valid && kind != KIND_INTERP |->
      second_pose == '0 && table_position == '0 && step_den == '0)
    else $error("step fields set outside interpolation");

endmodule

bind keyframe_frame_planner_unit kfp_checker u_kfp_checker (.*);
